// File: sv/dec_pkg.sv
package dec_pkg;

  // Fixed formats of the geometry path (radius Q8.8, trig Q1.16)
  localparam int TRIG_BITS  = 16;
  localparam int TRIG_ONE   = 1 << TRIG_BITS;
  localparam int CS_W       = TRIG_BITS + 2;
  localparam int RAD_W      = 16;
  localparam int MASS_W     = 16;
  localparam int MSUM_W     = MASS_W + 1;
  localparam int RS_W       = RAD_W + 1;
  localparam int SQR_W      = 2 * RS_W;
  localparam int D2_W       = SQR_W + 1;
  localparam int DIST_SHIFT = 16;
  localparam int SQ_W       = SQR_W + DIST_SHIFT;
  localparam int SQRT_STEPS = SQ_W / 2;
  localparam int DIST_W     = SQRT_STEPS;
  localparam int UNIT_SHIFT = 24;
  localparam int PUSH_W     = DIST_W + 1;

  // Shared divider format for the unit vector and the push
  localparam int GDIV_NUM_W = 44;
  localparam int GDIV_DEN_W = DIST_W + 1;
  localparam int GDIV_Q_W   = 19;
  localparam int EX_W       = GDIV_Q_W + 1;

  typedef struct packed {
    logic [RS_W-1:0] adx;
    logic [RS_W-1:0] ady;
    logic [RS_W-1:0] rs;
    logic            sx;
    logic            sy;
    logic            zero;
  } geo_t;

endpackage

// File: sv/disc_elastic_collision.sv
// Channel   Direction  Handshake                   Payload
// in        input      in_valid_i / in_ready_o     first_*_i, second_*_i (two discs)
// out       output     out_valid_o / out_ready_i   new_first_*_o, new_second_*_o, collided_o
//
// Accepts one disc pair per cycle while the output is not stalled; each result passes
// through the 25-step square root, the 19-step unit/push dividers and the
// VALUE_WIDTH + 4 step mass divider, one step per stage.
// Reset clears only the valid bits; payload registers are not reset.
// A stall on the output freezes every stage at once, so nothing is lost or repeated.
module disc_elastic_collision import dec_pkg::*; #(
  parameter int VALUE_WIDTH   = 24,
  parameter int FRACTION_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [VALUE_WIDTH-1:0] first_pos_x_i,
  input  logic signed [VALUE_WIDTH-1:0] first_pos_y_i,
  input  logic signed [VALUE_WIDTH-1:0] first_vel_x_i,
  input  logic signed [VALUE_WIDTH-1:0] first_vel_y_i,
  input  logic        [RAD_W-1:0]       first_radius_i,
  input  logic        [MASS_W-1:0]      first_mass_i,
  input  logic signed [VALUE_WIDTH-1:0] second_pos_x_i,
  input  logic signed [VALUE_WIDTH-1:0] second_pos_y_i,
  input  logic signed [VALUE_WIDTH-1:0] second_vel_x_i,
  input  logic signed [VALUE_WIDTH-1:0] second_vel_y_i,
  input  logic        [RAD_W-1:0]       second_radius_i,
  input  logic        [MASS_W-1:0]      second_mass_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [VALUE_WIDTH-1:0] new_first_pos_x_o,
  output logic signed [VALUE_WIDTH-1:0] new_first_pos_y_o,
  output logic signed [VALUE_WIDTH-1:0] new_first_vel_x_o,
  output logic signed [VALUE_WIDTH-1:0] new_first_vel_y_o,
  output logic signed [VALUE_WIDTH-1:0] new_second_pos_x_o,
  output logic signed [VALUE_WIDTH-1:0] new_second_pos_y_o,
  output logic signed [VALUE_WIDTH-1:0] new_second_vel_x_o,
  output logic signed [VALUE_WIDTH-1:0] new_second_vel_y_o,
  output logic                          collided_o
);

  localparam int W     = VALUE_WIDTH;
  localparam int UW    = W + 2;
  localparam int VP_W  = W + CS_W;
  localparam int NW    = UW + MSUM_W + 2;
  localparam int MQ_W  = NW - MSUM_W;
  localparam int PW    = MQ_W + 1;
  localparam int BP_W  = PW + CS_W;
  localparam int RND_W = BP_W + 1;
  localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(1) << (TRIG_BITS - 1);
  localparam logic [GDIV_Q_W-1:0] Q_ONE = GDIV_Q_W'(TRIG_ONE);

  typedef struct packed {
    logic signed [W-1:0] ax, ay, avx, avy, bx, by, bvx, bvy;
    logic [MASS_W-1:0]   am, bm;
    logic                hit;
  } item_t;

  typedef struct packed {
    item_t it;
    geo_t  geo;
  } ig_t;

  typedef struct packed {
    logic signed [CS_W-1:0] cs, sn;
    logic signed [W-1:0]    pax, pay, pbx, pby;
  } trig_t;

  typedef struct packed {
    logic signed [VP_W-1:0] avxc, avys, avyc, avxs, bvxc, bvys, bvyc, bvxs;
  } prod_t;

  typedef struct packed {
    logic signed [UW-1:0] u1, t1, u2, t2;
  } rot_t;

  typedef struct packed {
    logic signed [NW-1:0] m1a, m1b, m2a, m2b;
  } mprod_t;

  typedef struct packed {
    item_t it;
    trig_t tr;
    rot_t  ro;
    logic  neg1, neg2, msz;
  } md_t;

  typedef struct packed {
    logic signed [BP_W-1:0] p1c, t1s, p1s, t1c, p2c, t2s, p2s, t2c;
  } bprod_t;

  function automatic logic signed [RND_W-1:0] rnd_shr(input logic signed [RND_W-1:0] x);
    logic signed [RND_W-1:0] t;
    t = x + RND_HALF;
    return t >>> TRIG_BITS;
  endfunction

  function automatic logic signed [W-1:0] sat_val(input logic signed [RND_W-1:0] x);
    logic signed [RND_W-1:0] hi;
    logic signed [RND_W-1:0] lo;
    hi = {{(RND_W-W+1){1'b0}}, {(W-1){1'b1}}};
    lo = ~hi;
    if (x > hi) return hi[W-1:0];
    else if (x < lo) return lo[W-1:0];
    else return x[W-1:0];
  endfunction

  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // ---------------- stage 1: differences, radius sum, coarse test
  logic signed [W:0] dx_c, dy_c;
  logic [W:0]        adx_c, ady_c;
  logic [RS_W-1:0]   rs_c;
  logic              v1_q, near1_q;
  item_t             it1_q;
  geo_t              geo1_q;

  assign dx_c  = (W+1)'(second_pos_x_i) - (W+1)'(first_pos_x_i);
  assign dy_c  = (W+1)'(second_pos_y_i) - (W+1)'(first_pos_y_i);
  assign adx_c = dx_c[W] ? (W+1)'(-dx_c) : (W+1)'(dx_c);
  assign ady_c = dy_c[W] ? (W+1)'(-dy_c) : (W+1)'(dy_c);
  assign rs_c  = RS_W'(first_radius_i) + RS_W'(second_radius_i);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      it1_q.ax   <= first_pos_x_i;
      it1_q.ay   <= first_pos_y_i;
      it1_q.avx  <= first_vel_x_i;
      it1_q.avy  <= first_vel_y_i;
      it1_q.am   <= first_mass_i;
      it1_q.bx   <= second_pos_x_i;
      it1_q.by   <= second_pos_y_i;
      it1_q.bvx  <= second_vel_x_i;
      it1_q.bvy  <= second_vel_y_i;
      it1_q.bm   <= second_mass_i;
      it1_q.hit  <= 1'b0;
      geo1_q.adx <= RS_W'(adx_c);
      geo1_q.ady <= RS_W'(ady_c);
      geo1_q.rs  <= rs_c;
      geo1_q.sx  <= dx_c[W];
      geo1_q.sy  <= dy_c[W];
      geo1_q.zero <= 1'b0;
      near1_q    <= (adx_c < (W+1)'(rs_c)) && (ady_c < (W+1)'(rs_c));
    end
  end

  // ---------------- stage 2: squares
  logic            v2_q, near2_q;
  item_t           it2_q;
  geo_t            geo2_q;
  logic [SQR_W-1:0] sqx2_q, sqy2_q, rr2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      it2_q   <= it1_q;
      geo2_q  <= geo1_q;
      near2_q <= near1_q;
      sqx2_q  <= geo1_q.adx * geo1_q.adx;
      sqy2_q  <= geo1_q.ady * geo1_q.ady;
      rr2_q   <= geo1_q.rs * geo1_q.rs;
    end
  end

  // ---------------- stage 3: squared distance and exact overlap test
  logic [D2_W-1:0]  d2_c;
  logic             v3_q;
  item_t            it3_q;
  geo_t             geo3_q;
  logic [SQR_W-1:0] d2_3_q;

  assign d2_c = D2_W'(sqx2_q) + D2_W'(sqy2_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      it3_q       <= it2_q;
      it3_q.hit   <= near2_q && (d2_c < D2_W'(rr2_q));
      geo3_q      <= geo2_q;
      geo3_q.zero <= (d2_c == '0);
      d2_3_q      <= SQR_W'(d2_c);
    end
  end

  // ---------------- square root, one result bit per stage
  logic [SQ_W-1:0] sqv_in [SQRT_STEPS];
  logic [SQ_W-1:0] sqr_in [SQRT_STEPS];
  logic [SQ_W-1:0] sqv_q  [SQRT_STEPS-1];
  logic [SQ_W-1:0] sqr_q  [SQRT_STEPS];
  ig_t             sqs_q  [SQRT_STEPS];
  logic            sqvld_q [SQRT_STEPS];

  assign sqv_in[0] = {d2_3_q, {DIST_SHIFT{1'b0}}};
  assign sqr_in[0] = '0;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
    logic [SQ_W-1:0] trial;
    logic            ge;
    assign trial = sqr_in[k] + BIT;
    assign ge    = (sqv_in[k] >= trial);
    if (k > 0) begin : g_link
      assign sqv_in[k] = sqv_q[k-1];
      assign sqr_in[k] = sqr_q[k-1];
      always_ff @(posedge clk_i) begin
        if (adv) sqs_q[k] <= sqs_q[k-1];
      end
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) sqvld_q[k] <= 1'b0;
        else if (adv) sqvld_q[k] <= sqvld_q[k-1];
      end
    end else begin : g_head
      always_ff @(posedge clk_i) begin
        if (adv) sqs_q[k] <= '{it: it3_q, geo: geo3_q};
      end
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) sqvld_q[k] <= 1'b0;
        else if (adv) sqvld_q[k] <= v3_q;
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) sqr_q[k] <= ge ? ((sqr_in[k] >> 1) + BIT) : (sqr_in[k] >> 1);
    end
    if (k < SQRT_STEPS - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (adv) sqv_q[k] <= ge ? (sqv_in[k] - trial) : sqv_in[k];
      end
    end
  end

  // ---------------- stage 4: push length and divider operands
  logic [DIST_W-1:0]          dist_c;
  logic [PUSH_W-1:0]          push_c;
  logic [RS_W+PUSH_W-1:0]     prx_c, pry_c;
  logic                       v4_q;
  ig_t                        s4_q;
  logic [GDIV_NUM_W-1:0]      ntx4_q, nty4_q, npx4_q, npy4_q;
  logic [GDIV_DEN_W-1:0]      dent4_q, denp4_q;

  assign dist_c = sqr_q[SQRT_STEPS-1][DIST_W-1:0];
  assign push_c = PUSH_W'({sqs_q[SQRT_STEPS-1].geo.rs, 8'b0}) - PUSH_W'(dist_c)
                + (PUSH_W'(1) << (FRACTION_BITS + 8));
  assign prx_c  = sqs_q[SQRT_STEPS-1].geo.adx * push_c;
  assign pry_c  = sqs_q[SQRT_STEPS-1].geo.ady * push_c;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_q    <= sqs_q[SQRT_STEPS-1];
      ntx4_q  <= GDIV_NUM_W'(sqs_q[SQRT_STEPS-1].geo.adx) << UNIT_SHIFT;
      nty4_q  <= GDIV_NUM_W'(sqs_q[SQRT_STEPS-1].geo.ady) << UNIT_SHIFT;
      npx4_q  <= GDIV_NUM_W'(prx_c);
      npy4_q  <= GDIV_NUM_W'(pry_c);
      dent4_q <= GDIV_DEN_W'(dist_c);
      denp4_q <= {dist_c, 1'b0};
    end
  end

  // ---------------- unit vector and push dividers
  logic [GDIV_Q_W-1:0] qcx, qcy, qex, qey;
  ig_t                 dvs_q   [GDIV_Q_W];
  logic                dvvld_q [GDIV_Q_W];

  dec_div_pipe #(.NUM_W(GDIV_NUM_W), .DEN_W(GDIV_DEN_W), .Q_W(GDIV_Q_W)) u_div_cos (
    .clk_i(clk_i), .en_i(adv), .num_i(ntx4_q), .den_i(dent4_q), .quo_o(qcx));
  dec_div_pipe #(.NUM_W(GDIV_NUM_W), .DEN_W(GDIV_DEN_W), .Q_W(GDIV_Q_W)) u_div_sin (
    .clk_i(clk_i), .en_i(adv), .num_i(nty4_q), .den_i(dent4_q), .quo_o(qcy));
  dec_div_pipe #(.NUM_W(GDIV_NUM_W), .DEN_W(GDIV_DEN_W), .Q_W(GDIV_Q_W)) u_div_ex (
    .clk_i(clk_i), .en_i(adv), .num_i(npx4_q), .den_i(denp4_q), .quo_o(qex));
  dec_div_pipe #(.NUM_W(GDIV_NUM_W), .DEN_W(GDIV_DEN_W), .Q_W(GDIV_Q_W)) u_div_ey (
    .clk_i(clk_i), .en_i(adv), .num_i(npy4_q), .den_i(denp4_q), .quo_o(qey));

  for (genvar k = 0; k < GDIV_Q_W; k++) begin : g_dvside
    if (k > 0) begin : g_link
      always_ff @(posedge clk_i) begin
        if (adv) dvs_q[k] <= dvs_q[k-1];
      end
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) dvvld_q[k] <= 1'b0;
        else if (adv) dvvld_q[k] <= dvvld_q[k-1];
      end
    end else begin : g_head
      always_ff @(posedge clk_i) begin
        if (adv) dvs_q[k] <= s4_q;
      end
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) dvvld_q[k] <= 1'b0;
        else if (adv) dvvld_q[k] <= v4_q;
      end
    end
  end

  // ---------------- stage 5: signed cos/sin, separated positions
  ig_t                   d5;
  logic [CS_W-2:0]       magc, mags;
  logic signed [CS_W-1:0] cs_c, sn_c;
  logic signed [EX_W-1:0] ex_c, ey_c;
  logic                  v5_q;
  item_t                 it5_q;
  trig_t                 tr5_q;

  assign d5   = dvs_q[GDIV_Q_W-1];
  assign magc = (qcx > Q_ONE) ? (CS_W-1)'(TRIG_ONE) : qcx[CS_W-2:0];
  assign mags = (qcy > Q_ONE) ? (CS_W-1)'(TRIG_ONE) : qcy[CS_W-2:0];
  assign cs_c = d5.geo.zero ? CS_W'(TRIG_ONE)
              : (d5.geo.sx ? -$signed({1'b0, magc}) : $signed({1'b0, magc}));
  assign sn_c = d5.geo.zero ? '0
              : (d5.geo.sy ? -$signed({1'b0, mags}) : $signed({1'b0, mags}));
  assign ex_c = d5.geo.sx ? -$signed({1'b0, qex}) : $signed({1'b0, qex});
  assign ey_c = d5.geo.sy ? -$signed({1'b0, qey}) : $signed({1'b0, qey});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      it5_q     <= d5.it;
      tr5_q.cs  <= cs_c;
      tr5_q.sn  <= sn_c;
      tr5_q.pax <= d5.geo.zero ? d5.it.ax : sat_val(RND_W'(d5.it.ax) - RND_W'(ex_c));
      tr5_q.pay <= d5.geo.zero ? d5.it.ay : sat_val(RND_W'(d5.it.ay) - RND_W'(ey_c));
      tr5_q.pbx <= d5.geo.zero ? d5.it.bx : sat_val(RND_W'(d5.it.bx) + RND_W'(ex_c));
      tr5_q.pby <= d5.geo.zero ? d5.it.by : sat_val(RND_W'(d5.it.by) + RND_W'(ey_c));
    end
  end

  // ---------------- stage 6: forward rotation products
  logic  v6_q;
  item_t it6_q;
  trig_t tr6_q;
  prod_t pr6_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      it6_q      <= it5_q;
      tr6_q      <= tr5_q;
      pr6_q.avxc <= it5_q.avx * tr5_q.cs;
      pr6_q.avys <= it5_q.avy * tr5_q.sn;
      pr6_q.avyc <= it5_q.avy * tr5_q.cs;
      pr6_q.avxs <= it5_q.avx * tr5_q.sn;
      pr6_q.bvxc <= it5_q.bvx * tr5_q.cs;
      pr6_q.bvys <= it5_q.bvy * tr5_q.sn;
      pr6_q.bvyc <= it5_q.bvy * tr5_q.cs;
      pr6_q.bvxs <= it5_q.bvx * tr5_q.sn;
    end
  end

  // ---------------- stage 7: normal and tangential speeds
  logic  v7_q;
  item_t it7_q;
  trig_t tr7_q;
  rot_t  ro7_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      it7_q    <= it6_q;
      tr7_q    <= tr6_q;
      ro7_q.u1 <= UW'(rnd_shr(RND_W'(pr6_q.avxc) + RND_W'(pr6_q.avys)));
      ro7_q.t1 <= UW'(rnd_shr(RND_W'(pr6_q.avyc) - RND_W'(pr6_q.avxs)));
      ro7_q.u2 <= UW'(rnd_shr(RND_W'(pr6_q.bvxc) + RND_W'(pr6_q.bvys)));
      ro7_q.t2 <= UW'(rnd_shr(RND_W'(pr6_q.bvyc) - RND_W'(pr6_q.bvxs)));
    end
  end

  // ---------------- stage 8: mass products
  logic signed [MSUM_W-1:0] dm_c;
  logic signed [MSUM_W:0]   tam_c, tbm_c;
  logic                     v8_q;
  item_t                    it8_q;
  trig_t                    tr8_q;
  rot_t                     ro8_q;
  mprod_t                   mp8_q;
  logic [MSUM_W-1:0]        msum8_q;

  assign dm_c  = $signed({1'b0, it7_q.am}) - $signed({1'b0, it7_q.bm});
  assign tam_c = $signed({1'b0, it7_q.am, 1'b0});
  assign tbm_c = $signed({1'b0, it7_q.bm, 1'b0});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      it8_q     <= it7_q;
      tr8_q     <= tr7_q;
      ro8_q     <= ro7_q;
      mp8_q.m1a <= ro7_q.u1 * dm_c;
      mp8_q.m1b <= ro7_q.u2 * tbm_c;
      mp8_q.m2a <= ro7_q.u2 * (-dm_c);
      mp8_q.m2b <= ro7_q.u1 * tam_c;
      msum8_q   <= MSUM_W'(it7_q.am) + MSUM_W'(it7_q.bm);
    end
  end

  // ---------------- stage 9: numerators to sign and magnitude
  logic signed [NW-1:0] n1_c, n2_c;
  logic                 v9_q;
  md_t                  md9_q;
  logic [NW-1:0]        mag1_9_q, mag2_9_q;
  logic [MSUM_W-1:0]    msum9_q;

  assign n1_c = mp8_q.m1a + mp8_q.m1b;
  assign n2_c = mp8_q.m2a + mp8_q.m2b;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      md9_q.it   <= it8_q;
      md9_q.tr   <= tr8_q;
      md9_q.ro   <= ro8_q;
      md9_q.neg1 <= n1_c[NW-1];
      md9_q.neg2 <= n2_c[NW-1];
      md9_q.msz  <= (msum8_q == '0);
      mag1_9_q   <= n1_c[NW-1] ? NW'(-n1_c) : NW'(n1_c);
      mag2_9_q   <= n2_c[NW-1] ? NW'(-n2_c) : NW'(n2_c);
      msum9_q    <= msum8_q;
    end
  end

  // ---------------- mass dividers
  logic [MQ_W-1:0] q1, q2;
  md_t             mds_q   [MQ_W];
  logic            mdvld_q [MQ_W];

  dec_div_pipe #(.NUM_W(NW), .DEN_W(MSUM_W), .Q_W(MQ_W)) u_div_p1 (
    .clk_i(clk_i), .en_i(adv), .num_i(mag1_9_q), .den_i(msum9_q), .quo_o(q1));
  dec_div_pipe #(.NUM_W(NW), .DEN_W(MSUM_W), .Q_W(MQ_W)) u_div_p2 (
    .clk_i(clk_i), .en_i(adv), .num_i(mag2_9_q), .den_i(msum9_q), .quo_o(q2));

  for (genvar k = 0; k < MQ_W; k++) begin : g_mdside
    if (k > 0) begin : g_link
      always_ff @(posedge clk_i) begin
        if (adv) mds_q[k] <= mds_q[k-1];
      end
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) mdvld_q[k] <= 1'b0;
        else if (adv) mdvld_q[k] <= mdvld_q[k-1];
      end
    end else begin : g_head
      always_ff @(posedge clk_i) begin
        if (adv) mds_q[k] <= md9_q;
      end
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) mdvld_q[k] <= 1'b0;
        else if (adv) mdvld_q[k] <= v9_q;
      end
    end
  end

  // ---------------- stage 10: signed normal speeds after the hit
  md_t                  m10;
  logic signed [PW-1:0] p1_c, p2_c;
  logic                 v10_q;
  item_t                it10_q;
  trig_t                tr10_q;
  rot_t                 ro10_q;
  logic signed [PW-1:0] p1_10_q, p2_10_q;

  assign m10  = mds_q[MQ_W-1];
  // equal zero masses exchange the normal speeds
  assign p1_c = m10.msz ? PW'(m10.ro.u2)
              : (m10.neg1 ? -$signed({1'b0, q1}) : $signed({1'b0, q1}));
  assign p2_c = m10.msz ? PW'(m10.ro.u1)
              : (m10.neg2 ? -$signed({1'b0, q2}) : $signed({1'b0, q2}));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      it10_q  <= m10.it;
      tr10_q  <= m10.tr;
      ro10_q  <= m10.ro;
      p1_10_q <= p1_c;
      p2_10_q <= p2_c;
    end
  end

  // ---------------- stage 11: back rotation products
  logic   v11_q;
  item_t  it11_q;
  trig_t  tr11_q;
  bprod_t bp11_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      it11_q     <= it10_q;
      tr11_q     <= tr10_q;
      bp11_q.p1c <= p1_10_q * tr10_q.cs;
      bp11_q.t1s <= ro10_q.t1 * tr10_q.sn;
      bp11_q.p1s <= p1_10_q * tr10_q.sn;
      bp11_q.t1c <= ro10_q.t1 * tr10_q.cs;
      bp11_q.p2c <= p2_10_q * tr10_q.cs;
      bp11_q.t2s <= ro10_q.t2 * tr10_q.sn;
      bp11_q.p2s <= p2_10_q * tr10_q.sn;
      bp11_q.t2c <= ro10_q.t2 * tr10_q.cs;
    end
  end

  // ---------------- stage 12: output register, round, saturate, select
  logic                v12_q, col12_q;
  logic signed [W-1:0] o_ax_q, o_ay_q, o_avx_q, o_avy_q, o_bx_q, o_by_q, o_bvx_q, o_bvy_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      col12_q <= it11_q.hit;
      if (it11_q.hit) begin
        o_ax_q  <= tr11_q.pax;
        o_ay_q  <= tr11_q.pay;
        o_bx_q  <= tr11_q.pbx;
        o_by_q  <= tr11_q.pby;
        o_avx_q <= sat_val(rnd_shr(RND_W'(bp11_q.p1c) - RND_W'(bp11_q.t1s)));
        o_avy_q <= sat_val(rnd_shr(RND_W'(bp11_q.p1s) + RND_W'(bp11_q.t1c)));
        o_bvx_q <= sat_val(rnd_shr(RND_W'(bp11_q.p2c) - RND_W'(bp11_q.t2s)));
        o_bvy_q <= sat_val(rnd_shr(RND_W'(bp11_q.p2s) + RND_W'(bp11_q.t2c)));
      end else begin
        o_ax_q  <= it11_q.ax;
        o_ay_q  <= it11_q.ay;
        o_bx_q  <= it11_q.bx;
        o_by_q  <= it11_q.by;
        o_avx_q <= it11_q.avx;
        o_avy_q <= it11_q.avy;
        o_bvx_q <= it11_q.bvx;
        o_bvy_q <= it11_q.bvy;
      end
    end
  end

  // ---------------- valid bits of the short stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
      v11_q <= 1'b0;
      v12_q <= 1'b0;
    end else if (adv) begin
      v1_q  <= in_valid_i;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= sqvld_q[SQRT_STEPS-1];
      v5_q  <= dvvld_q[GDIV_Q_W-1];
      v6_q  <= v5_q;
      v7_q  <= v6_q;
      v8_q  <= v7_q;
      v9_q  <= v8_q;
      v10_q <= mdvld_q[MQ_W-1];
      v11_q <= v10_q;
      v12_q <= v11_q;
    end
  end

  assign out_valid_o        = v12_q;
  assign collided_o         = col12_q;
  assign new_first_pos_x_o  = o_ax_q;
  assign new_first_pos_y_o  = o_ay_q;
  assign new_first_vel_x_o  = o_avx_q;
  assign new_first_vel_y_o  = o_avy_q;
  assign new_second_pos_x_o = o_bx_q;
  assign new_second_pos_y_o = o_by_q;
  assign new_second_vel_x_o = o_bvx_q;
  assign new_second_vel_y_o = o_bvy_q;

endmodule

// File: sv/dec_div_pipe.sv
module dec_div_pipe #(
  parameter int NUM_W = 44,
  parameter int DEN_W = 26,
  parameter int Q_W   = 19
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [Q_W-1:0]   quo_o
);

  localparam int ACC_W = DEN_W + Q_W;

  logic [ACC_W-1:0] acc_in [Q_W];
  logic [ACC_W-1:0] acc_q  [Q_W];
  logic [DEN_W-1:0] den_in [Q_W];
  logic [DEN_W-1:0] den_q  [Q_W-1];

  // One restoring step: shift in the next numerator bit, subtract if it fits
  function automatic logic [ACC_W-1:0] div_step(input logic [ACC_W-1:0] acc,
                                                input logic [DEN_W-1:0] den);
    logic [DEN_W:0] sh;
    logic           ge;
    logic [DEN_W:0] rem;
    sh  = {acc[ACC_W-1:Q_W], acc[Q_W-1]};
    ge  = (sh >= {1'b0, den});
    rem = ge ? (sh - {1'b0, den}) : sh;
    return {rem[DEN_W-1:0], acc[Q_W-2:0], ge};
  endfunction

  // Upper numerator bits start as the partial remainder
  assign acc_in[0] = {DEN_W'(num_i[NUM_W-1:Q_W]), num_i[Q_W-1:0]};
  assign den_in[0] = den_i;

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    if (k > 0) begin : g_link
      assign acc_in[k] = acc_q[k-1];
      assign den_in[k] = den_q[k-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) acc_q[k] <= div_step(acc_in[k], den_in[k]);
    end
    if (k < Q_W - 1) begin : g_den
      always_ff @(posedge clk_i) begin
        if (en_i) den_q[k] <= den_in[k];
      end
    end
  end

  assign quo_o = acc_q[Q_W-1][Q_W-1:0];

endmodule

// File: bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW = 24;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT = 5000;
  localparam int RANDOM_PAIRS = 600;

  typedef struct packed {
    logic signed [VW-1:0] pos_x;
    logic signed [VW-1:0] pos_y;
    logic signed [VW-1:0] vel_x;
    logic signed [VW-1:0] vel_y;
    logic [15:0]          radius;
    logic [15:0]          mass;
  } disc_t;

  typedef struct packed {
    disc_t a;
    disc_t b;
  } disc_pair_t;

  typedef struct packed {
    logic signed [VW-1:0] a_pos_x, a_pos_y, a_vel_x, a_vel_y;
    logic signed [VW-1:0] b_pos_x, b_pos_y, b_vel_x, b_vel_y;
    logic                 collided;
  } bounce_t;

  // Expected outcomes of disc pairs, oldest first
  class bounce_board;
    bounce_t outcomes[$];
    int      errors;

    function longint sat(longint v);
      longint hi;
      hi = (longint'(1) <<< (VW - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    function longint round16(longint v);
      return (v + (longint'(1) <<< 15)) >>> 16;
    endfunction

    function longint sqrt_floor(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return longint'(r);
    endfunction

    // Direction cosine in Q1.16, capped at one
    function longint unit_part(longint c, longint span);
      longint q;
      q = ((c < 0 ? -c : c) <<< 24) / span;
      if (q > 65536) q = 65536;
      return c < 0 ? -q : q;
    endfunction

    function bounce_t collide(disc_pair_t p);
      bounce_t r;
      longint ax, ay, bx, by, avx, avy, bvx, bvy, am, bm, rs, dx, dy, d2;
      longint span, cs, sn, u1, t1, u2, t2, p1, p2, push, ex, ey;
      bit hit;
      ax = p.a.pos_x; ay = p.a.pos_y; avx = p.a.vel_x; avy = p.a.vel_y;
      bx = p.b.pos_x; by = p.b.pos_y; bvx = p.b.vel_x; bvy = p.b.vel_y;
      am = p.a.mass; bm = p.b.mass;
      rs = longint'(p.a.radius) + longint'(p.b.radius);
      dx = bx - ax;
      dy = by - ay;
      r = {p.a.pos_x, p.a.pos_y, p.a.vel_x, p.a.vel_y,
           p.b.pos_x, p.b.pos_y, p.b.vel_x, p.b.vel_y, 1'b0};
      hit = 0;
      if ((dx < 0 ? -dx : dx) < rs && (dy < 0 ? -dy : dy) < rs)
        hit = (dx * dx + dy * dy) < rs * rs;
      if (!hit) return r;
      d2 = dx * dx + dy * dy;
      span = 0;
      cs = 65536;
      sn = 0;
      if (d2 != 0) begin
        span = sqrt_floor(longint'(d2) <<< 16);
        cs = unit_part(dx, span);
        sn = unit_part(dy, span);
      end
      // Rotate onto the line of centers, exchange momentum, rotate back
      u1 = round16(avx * cs + avy * sn);
      t1 = round16(avy * cs - avx * sn);
      u2 = round16(bvx * cs + bvy * sn);
      t2 = round16(bvy * cs - bvx * sn);
      if (am + bm == 0) begin
        p1 = u2;
        p2 = u1;
      end else begin
        p1 = (u1 * (am - bm) + 2 * bm * u2) / (am + bm);
        p2 = (u2 * (bm - am) + 2 * am * u1) / (am + bm);
      end
      r.a_vel_x = sat(round16(p1 * cs - t1 * sn));
      r.a_vel_y = sat(round16(p1 * sn + t1 * cs));
      r.b_vel_x = sat(round16(p2 * cs - t2 * sn));
      r.b_vel_y = sat(round16(p2 * sn + t2 * cs));
      // Push apart by half the overlap plus half a pixel each
      if (d2 != 0) begin
        push = rs * 256 - span + 65536;
        ex = (dx * push) / (2 * span);
        ey = (dy * push) / (2 * span);
        r.a_pos_x = sat(ax - ex);
        r.a_pos_y = sat(ay - ey);
        r.b_pos_x = sat(bx + ex);
        r.b_pos_y = sat(by + ey);
      end
      r.collided = 1'b1;
      return r;
    endfunction

    function void note_pair(disc_pair_t p);
      outcomes.push_back(collide(p));
    endfunction

    function void match(string name, longint want, longint got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_outcome(bounce_t got);
      bounce_t want;
      if (outcomes.size() == 0) begin
        $error("result transfer with no pair outstanding");
        errors++;
        return;
      end
      want = outcomes.pop_front();
      match("new_first_pos_x", want.a_pos_x, got.a_pos_x);
      match("new_first_pos_y", want.a_pos_y, got.a_pos_y);
      match("new_first_vel_x", want.a_vel_x, got.a_vel_x);
      match("new_first_vel_y", want.a_vel_y, got.a_vel_y);
      match("new_second_pos_x", want.b_pos_x, got.b_pos_x);
      match("new_second_pos_y", want.b_pos_y, got.b_pos_y);
      match("new_second_vel_x", want.b_vel_x, got.b_vel_x);
      match("new_second_vel_y", want.b_vel_y, got.b_vel_y);
      match("collided", want.collided, got.collided);
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 0;
  disc_pair_t pair_q = '0;
  bounce_t    outcome;
  bounce_board board = new();
  bit quiet = 0;
  bit hold_request = 0;

  always #4 clk = ~clk;

  disc_elastic_collision dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .first_pos_x_i     (pair_q.a.pos_x),
    .first_pos_y_i     (pair_q.a.pos_y),
    .first_vel_x_i     (pair_q.a.vel_x),
    .first_vel_y_i     (pair_q.a.vel_y),
    .first_radius_i    (pair_q.a.radius),
    .first_mass_i      (pair_q.a.mass),
    .second_pos_x_i    (pair_q.b.pos_x),
    .second_pos_y_i    (pair_q.b.pos_y),
    .second_vel_x_i    (pair_q.b.vel_x),
    .second_vel_y_i    (pair_q.b.vel_y),
    .second_radius_i   (pair_q.b.radius),
    .second_mass_i     (pair_q.b.mass),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .new_first_pos_x_o (outcome.a_pos_x),
    .new_first_pos_y_o (outcome.a_pos_y),
    .new_first_vel_x_o (outcome.a_vel_x),
    .new_first_vel_y_o (outcome.a_vel_y),
    .new_second_pos_x_o(outcome.b_pos_x),
    .new_second_pos_y_o(outcome.b_pos_y),
    .new_second_vel_x_o(outcome.b_vel_x),
    .new_second_vel_y_o(outcome.b_vel_y),
    .collided_o        (outcome.collided)
  );

  // Offer one pair and hold it until the transfer
  task automatic send_pair(disc_pair_t p);
    in_valid <= 1'b1;
    pair_q <= p;
    do @(posedge clk); while (!in_ready);
    board.note_pair(p);
  endtask

  task automatic sender_gap(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic disc_pair_t make_pair(
      longint ax, longint ay, longint avx, longint avy, int ar, int am,
      longint bx, longint by, longint bvx, longint bvy, int br, int bm);
    disc_pair_t p;
    p.a = '{ax[VW-1:0], ay[VW-1:0], avx[VW-1:0], avy[VW-1:0], ar[15:0], am[15:0]};
    p.b = '{bx[VW-1:0], by[VW-1:0], bvx[VW-1:0], bvy[VW-1:0], br[15:0], bm[15:0]};
    return p;
  endfunction

  function automatic longint rand_vel();
    case ($urandom_range(0, 3))
      0: return longint'($urandom_range(0, 2000)) - 1000;
      1: return longint'($urandom_range(0, 200000)) - 100000;
      default: return longint'(signed'(24'($urandom)));
    endcase
  endfunction

  function automatic int rand_mass();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return $urandom_range(1, 8);
      default: return $urandom_range(1, 65535);
    endcase
  endfunction

  function automatic int rand_radius();
    return $urandom_range(0, 1) ? $urandom_range(0, 4096) : $urandom_range(0, 65535);
  endfunction

  // Mostly overlapping pairs; some with positions anywhere
  function automatic disc_pair_t rand_pair();
    int ar, br;
    longint rs, ax, ay, dx, dy;
    ar = rand_radius();
    br = rand_radius();
    rs = longint'(ar) + br;
    ax = longint'(signed'(24'($urandom)));
    ay = longint'(signed'(24'($urandom)));
    if ($urandom_range(0, 6) == 0) begin
      dx = longint'(signed'(24'($urandom))) - ax;
      dy = longint'(signed'(24'($urandom))) - ay;
    end else begin
      dx = longint'($urandom_range(0, 2 * rs)) - rs;
      dy = longint'($urandom_range(0, 2 * rs)) - rs;
    end
    return make_pair(ax, ay, rand_vel(), rand_vel(), ar, rand_mass(),
                     ax + dx, ay + dy, rand_vel(), rand_vel(), br, rand_mass());
  endfunction

  // Receiver: random stall bursts, one long hold on request
  initial begin
    int stall;
    stall = 0;
    @(posedge rst_n);
    forever begin
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 0;
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 15) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
      if (out_valid && out_ready) board.check_outcome(outcome);
    end
  end

  // Watchdog on cycles without any transfer
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    localparam longint VMAX = 8388607;
    localparam longint VMIN = -8388608;
    disc_pair_t directed[$];
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Far apart, coincident centers, zero radii, zero masses
    directed.push_back(make_pair(0, 0, 100, -50, 256, 3, 100000, 0, 7, 9, 256, 5));
    directed.push_back(make_pair(5000, -7000, 300, 40, 512, 2, 5000, -7000, -200, 10, 512, 7));
    directed.push_back(make_pair(1234, 1234, 9, 9, 0, 4, 1234, 1234, -9, 1, 0, 4));
    directed.push_back(make_pair(0, 0, 700, 20, 1024, 0, 300, 100, -500, 0, 1024, 0));
    directed.push_back(make_pair(0, 0, 700, 20, 1024, 0, 300, 100, -500, 0, 1024, 9));
    directed.push_back(make_pair(0, 0, 256, 0, 512, 1, 700, 0, -256, 0, 512, 1));
    // Exactly touching along x: no hit
    directed.push_back(make_pair(0, 0, 256, 0, 512, 1, 1024, 0, -256, 0, 512, 1));
    // Push saturates at both ends of the range
    directed.push_back(make_pair(VMAX, VMAX, 1, 1, 65535, 10, VMAX - 256, VMAX - 256,
                                 2, 2, 65535, 10));
    directed.push_back(make_pair(VMIN, VMIN, 1, 1, 65535, 10, VMIN + 256, VMIN + 300,
                                 2, 2, 65535, 10));
    // Extreme velocities and masses, velocity saturation
    directed.push_back(make_pair(0, 0, VMAX, VMIN, 65535, 65535, 1000, -900,
                                 VMIN, VMAX, 65535, 1));
    directed.push_back(make_pair(0, 0, VMIN, VMIN, 65535, 1, -3000, 2000,
                                 VMAX, VMAX, 65535, 65535));
    directed.push_back(make_pair(100, 100, 512, 512, 300, 4, 300, 300, -512, -128, 300, 6));
    directed.push_back(make_pair(-1, -1, -1, -1, 65535, 65535, 0, 0, 0, 0, 0, 65535));
    directed.push_back(make_pair(VMAX, 0, 5, 5, 65535, 1, VMIN, 0, 5, 5, 65535, 1));
    directed.push_back(make_pair(0, VMIN, 0, 0, 0, 1, 0, VMAX, 0, 0, 0, 1));
    foreach (directed[i]) send_pair(directed[i]);

    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      if (n == 200) hold_request = 1;
      if (n == 350) begin
        in_valid <= 1'b0;
        wait (board.outcomes.size() == 0);
        @(posedge clk);
      end
      if (n == RANDOM_PAIRS - 120) quiet = 1;
      if (!quiet && $urandom_range(0, 9) == 0) sender_gap($urandom_range(1, 15));
      send_pair(rand_pair());
    end
    in_valid <= 1'b0;

    wait (board.outcomes.size() == 0);
    repeat (120) @(posedge clk);
    if (board.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// File: disc_elastic_collision.f
sv/dec_pkg.sv
sv/dec_div_pipe.sv
sv/disc_elastic_collision.sv
bench/testbench.sv
